// File: sv/refcounted_page_allocator_assert.svh
// assertion macros for the page allocator checker
`ifndef REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/rpa_pkg.sv
// shared types and constants of the page allocator
package rpa_pkg;
  localparam int NUM_PAGES_D   = 32768;
  localparam int PAGE_SHIFT_D  = 12;
  localparam int COUNT_WIDTH_D = 16;
  localparam int QDEPTH        = 2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INCR  = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END   = 1'b1;

  // classified command from front to back (index kept at full 32-bit width)
  typedef struct packed {
    logic [1:0]  op;
    logic        bad;
    logic [31:0] idx;
  } cmd_t;
endpackage

// File: sv/refcounted_page_allocator.sv
// top level of the reference-counted page allocator
// alloc, free and incref pass through queue pop, memory read and modify/write before
//   out_tvalid rises; one item at a time in the back end
// the back end takes no new item until its result beat is taken (pop, read, modify/write, result beat)
// init: the sweep writes one stack and one count entry a cycle, then gives its result beat
// reset: rst_n synchronous active low; region latched as empty, stack depth zero
module refcounted_page_allocator #(
  parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_D,
  parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_D,
  parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], page_addr[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[2:0], alloc_addr[34:3], still_referenced[35],
                                  // free_count[51:36], zero pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);
  // configuration registers
  logic [31:0] region_start_r, region_end_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= 32'h8000_0000;
      region_end_r   <= 32'h8800_0000;
    end else if (cfg_we) begin
      if (cfg_addr == rpa_pkg::CFG_REGION_START) region_start_r <= cfg_wdata;
      else region_end_r <= cfg_wdata;
    end
  end

  logic          cmd_valid, cmd_ready;
  rpa_pkg::cmd_t cmd;
  logic [32:0]   base;
  logic [31:0]   pages;
  logic [2:0]    status;
  logic [31:0]   alloc_addr;
  logic          still;
  logic [15:0]   free_count;

  // front classifies against the region latched by the last init
  rpa_front #(.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[1:0]), .page_addr(in_tdata[33:2]),
    .base, .pages,
    .cmd_valid, .cmd_ready, .cmd
  );

  rpa_back #(.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT),
             .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst_n,
    .cmd_valid, .cmd_ready, .cmd,
    .region_start(region_start_r), .region_end(region_end_r),
    .base, .pages,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .status, .alloc_addr, .still_referenced(still), .free_count
  );

  assign out_tdata = {4'd0, free_count, still, alloc_addr, status};
endmodule

// File: sv/rpa_front.sv
// front end: input queue, address check and index computation against the latched region
module rpa_front #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_D,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    op,
  input  logic [31:0]   page_addr,
  input  logic [32:0]   base,
  input  logic [31:0]   pages,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output rpa_pkg::cmd_t cmd
);
  rpa_pkg::cmd_t q_r [rpa_pkg::QDEPTH];
  logic          wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  rpa_pkg::cmd_t head;
  rpa_pkg::cmd_t c;
  logic [32:0]   diff;
  logic [32:0]   n;
  logic          push, pop;

  // queue holds raw op and address; the head is classified as it leaves, so an
  // init ahead of it in the back end has already latched the new region
  always_comb begin
    head  = q_r[rp_r];
    diff  = {1'b0, head.idx} - base;
    n     = diff >> PAGE_SHIFT;
    c.op  = head.op;
    c.idx = n[31:0];
    c.bad = (head.idx[PAGE_SHIFT-1:0] != '0) || ({1'b0, head.idx} < base) ||
            (n >= {1'b0, pages}) || (n >= 33'(NUM_PAGES));
  end

  assign in_ready  = (cnt_r != 2'(rpa_pkg::QDEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = c;
  assign wp_nxt    = push ? ~wp_r : wp_r;
  assign rp_nxt    = pop ? ~rp_r : rp_r;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= '{op: op, bad: 1'b0, idx: page_addr};
  end
endmodule

// File: sv/rpa_back.sv
// back end: stack and count memories, read-modify-write sequencer, init sweep
module rpa_back #(
  parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_D,
  parameter int PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_D,
  parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  rpa_pkg::cmd_t cmd,
  input  logic [31:0]   region_start,
  input  logic [31:0]   region_end,
  output logic [32:0]   base,
  output logic [31:0]   pages,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [31:0]   alloc_addr,
  output logic          still_referenced,
  output logic [15:0]   free_count
);
  localparam int IW = $clog2(NUM_PAGES);
  localparam int DW = IW + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_MOD = 3'd2,
                         S_INIT = 3'd3, S_OUT = 3'd4;

  logic [IW-1:0]          stk_mem [NUM_PAGES];
  logic [COUNT_WIDTH-1:0] ref_mem [NUM_PAGES];

  logic [2:0]             st_r, st_nxt;
  rpa_pkg::cmd_t          c_r;
  logic [DW-1:0]          depth_r, depth_nxt;
  logic [32:0]            base_r;
  logic [31:0]            pages_r;
  logic [DW-1:0]          ipos_r;
  logic [IW-1:0]          stk_q_r;
  logic [COUNT_WIDTH-1:0] ref_q_r;
  logic [2:0]             st_o_r;
  logic [31:0]            addr_o_r;
  logic                   still_o_r;

  logic [32:0] rbase;
  logic [32:0] ipages;
  logic [32:0] span;
  logic [IW-1:0] aidx;
  logic [32:0]   aaddr;

  assign base      = base_r;
  assign pages     = pages_r;
  assign cmd_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign status           = st_o_r;
  assign alloc_addr       = addr_o_r;
  assign still_referenced = still_o_r;
  assign free_count       = 16'(depth_r);

  always_comb begin
    rbase = ({1'b0, region_start} + 33'((64'd1 << PAGE_SHIFT) - 1)) &
            ~33'((64'd1 << PAGE_SHIFT) - 1);
    span  = {1'b0, region_end} - rbase;
    if (rbase > {1'b0, region_end}) ipages = '0;
    else ipages = span >> PAGE_SHIFT;
    if (ipages > 33'(NUM_PAGES)) ipages = 33'(NUM_PAGES);
    aidx  = stk_q_r;
    aaddr = base_r + (33'(aidx) << PAGE_SHIFT);
  end

  always_comb begin
    st_nxt    = st_r;
    depth_nxt = depth_r;
    case (st_r)
      S_IDLE: if (cmd_valid) st_nxt = (cmd.op == rpa_pkg::OP_INIT) ? S_INIT : S_READ;
      S_READ: st_nxt = S_MOD;
      S_MOD:  st_nxt = S_OUT;
      S_INIT: if (ipos_r == DW'(pages_r) || ipos_r == DW'(NUM_PAGES)) st_nxt = S_OUT;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      depth_r <= '0;
      base_r  <= '0;
      pages_r <= '0;
      ipos_r  <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (cmd_valid) begin
          c_r <= cmd;
          if (cmd.op == rpa_pkg::OP_INIT) begin
            base_r   <= rbase;
            pages_r  <= ipages[31:0];
            ipos_r   <= '0;
            depth_r  <= '0;
            st_o_r   <= rpa_pkg::ST_OK;
            addr_o_r <= '0;
            still_o_r <= 1'b0;
          end
        end
        S_READ: begin
          // memory read issued in this state
          st_o_r    <= rpa_pkg::ST_OK;
          addr_o_r  <= '0;
          still_o_r <= 1'b0;
        end
        S_MOD: begin
          case (c_r.op)
            rpa_pkg::OP_ALLOC: begin
              if (depth_r == '0) st_o_r <= rpa_pkg::ST_EMPTY;
              else begin
                depth_r  <= depth_r - 1'b1;
                addr_o_r <= aaddr[31:0];
              end
            end
            rpa_pkg::OP_FREE: begin
              if (c_r.bad) st_o_r <= rpa_pkg::ST_BAD_ADDR;
              else if (ref_q_r == '0) st_o_r <= rpa_pkg::ST_NOT_ALLOC;
              else if (ref_q_r != COUNT_WIDTH'(1)) still_o_r <= 1'b1;
              else if (depth_r < DW'(NUM_PAGES)) depth_r <= depth_r + 1'b1;
            end
            rpa_pkg::OP_INCR: begin
              if (c_r.bad) st_o_r <= rpa_pkg::ST_BAD_ADDR;
              else if (ref_q_r == '0) st_o_r <= rpa_pkg::ST_NOT_ALLOC;
              else if (ref_q_r == '1) st_o_r <= rpa_pkg::ST_SATURATED;
            end
            default: ;
          endcase
        end
        S_INIT: if (st_nxt == S_INIT) begin
          ipos_r  <= ipos_r + 1'b1;
          depth_r <= depth_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // memory ports: one read at S_READ, one write at S_MOD or during init
  always_ff @(posedge clk) begin
    if (st_r == S_READ) begin
      stk_q_r <= stk_mem[IW'(depth_r - 1'b1)];
      ref_q_r <= ref_mem[c_r.idx[IW-1:0]];
    end
    if (st_r == S_INIT && st_nxt == S_INIT) begin
      stk_mem[ipos_r[IW-1:0]] <= ipos_r[IW-1:0];
      ref_mem[ipos_r[IW-1:0]] <= '0;
    end else if (st_r == S_MOD) begin
      case (c_r.op)
        rpa_pkg::OP_ALLOC: if (depth_r != '0) ref_mem[aidx] <= COUNT_WIDTH'(1);
        rpa_pkg::OP_FREE: if (!c_r.bad && ref_q_r != '0) begin
          ref_mem[c_r.idx[IW-1:0]] <= ref_q_r - 1'b1;
          if (ref_q_r == COUNT_WIDTH'(1) && depth_r < DW'(NUM_PAGES))
            stk_mem[depth_r[IW-1:0]] <= c_r.idx[IW-1:0];
        end
        rpa_pkg::OP_INCR: if (!c_r.bad && ref_q_r != '0 && ref_q_r != '1)
          ref_mem[c_r.idx[IW-1:0]] <= ref_q_r + 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// File: sv/rpa_checker.sv
// port-level checker for the page allocator and its bind
`include "refcounted_page_allocator_assert.svh"
module rpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  logic [2:0]  st;
  logic [31:0] aaddr;
  logic        still;
  logic [15:0] fcnt;

  assign st    = out_tdata[2:0];
  assign aaddr = out_tdata[34:3];
  assign still = out_tdata[35];
  assign fcnt  = out_tdata[51:36];

  // a failed item reports no page address
  `RPA_ASSERT_IMP(a_empty_no_addr, clk, rst_n, out_tvalid && st != rpa_pkg::ST_OK, aaddr == '0)
  // still_referenced only with ok status
  `RPA_ASSERT_IMP(a_still_ok, clk, rst_n, out_tvalid && still, st == rpa_pkg::ST_OK)
  // free count never exceeds the page range
  `RPA_ASSERT_IMP(a_count_range, clk, rst_n, out_tvalid, fcnt <= 16'(rpa_pkg::NUM_PAGES_D))
  // a stalled result holds
  `RPA_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // an offered input beat stays offered until taken
  `RPA_ASSERT_NXT(a_in_hold, clk, rst_n, in_tvalid && !in_tready, in_tvalid)
endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

// File: tb/testbench.sv
// self-checking testbench for the reference-counted page allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES   = rpa_pkg::NUM_PAGES_D;
  localparam int PSHIFT   = rpa_pkg::PAGE_SHIFT_D;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // one result beat, split into its fields
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] alloc_addr;
    logic        still;
    logic [15:0] free_count;
  } alloc_res_t;

  // directed stimulus: either a register write or an item, optionally with a typed result
  typedef struct {
    bit          is_cfg;
    logic        reg_sel;
    logic [1:0]  op;
    logic [31:0] val;
    bit          typed;
    alloc_res_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // op[1:0], page_addr[33:2], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // status[2:0], alloc_addr[34:3], still_referenced[35],
                            // free_count[51:36], zero pad
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;

  refcounted_page_allocator dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  // ---------------- allocator shadow state ----------------
  logic [31:0] reg_start, reg_end;   // register copies; the region is latched from them only by init
  logic [32:0] shadow_base;
  int          shadow_pages;
  int          shadow_depth;
  int          shadow_stack [NPAGES];
  logic [15:0] shadow_refs  [NPAGES];
  logic [31:0] recent_pages [$];     // recently handed-out pages, to aim frees at

  alloc_res_t  pending_results [$];
  int          errors;
  int          items_sent, beats_seen;
  int          status_seen [5];
  bit          tx_no_idle, rx_no_idle, rx_hold_req;

  // map an address to its page index in the latched region
  function automatic bit page_lookup(input logic [31:0] addr, output int idx);
    logic [32:0] off;
    idx = 0;
    if (addr[PSHIFT-1:0] != '0 || {1'b0, addr} < shadow_base) return 0;
    off = ({1'b0, addr} - shadow_base) >> PSHIFT;
    if (off >= 33'(shadow_pages)) return 0;
    idx = int'(off);
    return 1;
  endfunction

  // advance the shadow allocator by one item and return its result
  function automatic alloc_res_t allocator_step(input logic [1:0] op, input logic [31:0] addr);
    alloc_res_t  r;
    int          idx;
    logic [32:0] top, base, npg;
    r = '0;
    r.status = rpa_pkg::ST_OK;
    case (op)
      rpa_pkg::OP_ALLOC: begin
        if (shadow_depth == 0) begin
          r.status = rpa_pkg::ST_EMPTY;
        end else begin
          shadow_depth--;
          idx = shadow_stack[shadow_depth];
          shadow_refs[idx] = 16'd1;
          r.alloc_addr = 32'(shadow_base + (33'(idx) << PSHIFT));
        end
      end
      rpa_pkg::OP_FREE: begin
        if (!page_lookup(addr, idx)) begin
          r.status = rpa_pkg::ST_BAD_ADDR;
        end else if (shadow_refs[idx] == 0) begin
          r.status = rpa_pkg::ST_NOT_ALLOC;
        end else begin
          shadow_refs[idx]--;
          if (shadow_refs[idx] != 0) begin
            r.still = 1'b1;
          end else if (shadow_depth < NPAGES) begin
            shadow_stack[shadow_depth] = idx;
            shadow_depth++;
          end
        end
      end
      rpa_pkg::OP_INCR: begin
        if (!page_lookup(addr, idx)) r.status = rpa_pkg::ST_BAD_ADDR;
        else if (shadow_refs[idx] == 0) r.status = rpa_pkg::ST_NOT_ALLOC;
        else if (shadow_refs[idx] >= COUNT_MAX) r.status = rpa_pkg::ST_SATURATED;
        else shadow_refs[idx]++;
      end
      default: begin
        // rebuild: round base up to a page, count whole pages, clamp to table size
        base = ({1'b0, reg_start} + ((33'd1 << PSHIFT) - 1)) & ~((33'd1 << PSHIFT) - 1);
        top  = {1'b0, reg_end};
        npg  = (base <= top) ? ((top - base) >> PSHIFT) : 33'd0;
        if (npg > 33'(NPAGES)) npg = 33'(NPAGES);
        shadow_base  = base;
        shadow_pages = int'(npg);
        for (int i = 0; i < shadow_pages; i++) begin
          shadow_stack[i] = i;
          shadow_refs[i]  = '0;
        end
        shadow_depth = shadow_pages;
        recent_pages.delete();
      end
    endcase
    r.free_count = 16'(shadow_depth);
    return r;
  endfunction

  // ---------------- clock, limit ----------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // full-table init sweeps dominate; this is several times the slowest correct run
  initial begin
    #40_000_000;
    $display("timeout at %0t, %0d results still outstanding", $time, pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------- sender ----------------
  task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                           input bit typed, input alloc_res_t typed_res);
    int         gap;
    alloc_res_t r;
    gap = tx_no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, addr, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // beat taken at this edge: predict in acceptance order
    r = allocator_step(op, addr);
    if (op == rpa_pkg::OP_ALLOC && r.status == rpa_pkg::ST_OK) begin
      recent_pages.push_back(r.alloc_addr);
      if (recent_pages.size() > 16) void'(recent_pages.pop_front());
    end
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // drop valid and let every outstanding result come back, then the pipe settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only issued with the block drained
  task automatic write_reg(input logic sel, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (sel == rpa_pkg::CFG_REGION_START) reg_start = val;
    else reg_end = val;
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    alloc_res_t got, want;
    int         gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold_req) begin
        // long stall: the input side keeps offering and must back up
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        gap = rx_no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = alloc_res_t'({out_tdata[2:0], out_tdata[34:3], out_tdata[35], out_tdata[51:36]});
      beats_seen++;
      if (got.status <= rpa_pkg::ST_SATURATED) status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.alloc_addr !== want.alloc_addr) begin
          $display("%0t: alloc_addr expected %h got %h", $time, want.alloc_addr, got.alloc_addr);
          errors++;
        end
        if (got.still !== want.still) begin
          $display("%0t: still_referenced expected %0b got %0b", $time, want.still, got.still);
          errors++;
        end
        if (got.free_count !== want.free_count) begin
          $display("%0t: free_count expected %0d got %0d", $time,
                   want.free_count, got.free_count);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  // pick a random region of a few dozen pages, sometimes with an unaligned start
  task automatic pick_small_region();
    logic [31:0] s;
    logic [32:0] b;
    s = $urandom_range(0, 32'hF000_0000);
    if ($urandom_range(0, 1)) s[PSHIFT-1:0] = '0;
    b = ({1'b0, s} + 4095) & ~33'hFFF;
    write_reg(rpa_pkg::CFG_REGION_START, s);
    write_reg(rpa_pkg::CFG_REGION_END, 32'(b + (33'($urandom_range(1, 48)) << PSHIFT)
                                           + $urandom_range(0, 4095)));
  endtask

  // one random item, mostly alloc/free/incref on pages actually in use
  task automatic random_item();
    int          pick;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    if (recent_pages.size() != 0)
      a = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    else
      a = 32'(shadow_base);
    if (pick < 40) begin
      send_item(rpa_pkg::OP_ALLOC, $urandom(), 0, '0);
    end else if (pick < 65) begin
      send_item(rpa_pkg::OP_FREE, a, 0, '0);
    end else if (pick < 80) begin
      send_item(rpa_pkg::OP_INCR, a, 0, '0);
    end else if (pick < 86) begin
      // any page of the region or the one just past it, often one that is free
      a = 32'(shadow_base + (33'($urandom_range(0, shadow_pages)) << PSHIFT));
      send_item($urandom_range(0, 1) ? rpa_pkg::OP_FREE : rpa_pkg::OP_INCR, a, 0, '0);
    end else if (pick < 97) begin
      // noise: arbitrary, often misaligned addresses
      a = $urandom();
      send_item($urandom_range(0, 1) ? rpa_pkg::OP_FREE : rpa_pkg::OP_INCR, a, 0, '0);
    end else begin
      send_item(rpa_pkg::OP_INIT, $urandom(), 0, '0);
    end
  endtask

  dir_row_t   dir_table [$];

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = rpa_pkg::CFG_REGION_START;
    cfg_wdata  = '0;
    reg_start  = 32'h8000_0000;
    reg_end    = 32'h8800_0000;
    shadow_base = '0; shadow_pages = 0; shadow_depth = 0;
    errors = 0; items_sent = 0; beats_seen = 0;
    tx_no_idle = 0; rx_no_idle = 0; rx_hold_req = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed table: region 0x2000..0x4fff gives three pages, top page 0x4000 first
    dir_table = '{
      // before any init the region is empty
      '{0, 0, rpa_pkg::OP_ALLOC, 32'h0, 1, '{rpa_pkg::ST_EMPTY, 32'h0, 0, 16'd0}},
      '{0, 0, rpa_pkg::OP_FREE, 32'hFFFF_FFFF, 1, '{rpa_pkg::ST_BAD_ADDR, 32'h0, 0, 16'd0}},
      '{0, 0, rpa_pkg::OP_INCR, 32'h0, 1, '{rpa_pkg::ST_BAD_ADDR, 32'h0, 0, 16'd0}},
      '{1, rpa_pkg::CFG_REGION_START, rpa_pkg::OP_INIT, 32'h0000_1001, 0, '0},
      '{1, rpa_pkg::CFG_REGION_END, rpa_pkg::OP_INIT, 32'h0000_5005, 0, '0},
      '{0, 0, rpa_pkg::OP_INIT, 32'hFFFF_FFFF, 1, '{rpa_pkg::ST_OK, 32'h0, 0, 16'd3}},
      '{0, 0, rpa_pkg::OP_ALLOC, 32'h0, 1, '{rpa_pkg::ST_OK, 32'h4000, 0, 16'd2}},
      '{0, 0, rpa_pkg::OP_ALLOC, 32'h0, 1, '{rpa_pkg::ST_OK, 32'h3000, 0, 16'd1}},
      '{0, 0, rpa_pkg::OP_INCR, 32'h4000, 1, '{rpa_pkg::ST_OK, 32'h0, 0, 16'd1}},
      '{0, 0, rpa_pkg::OP_FREE, 32'h4000, 1, '{rpa_pkg::ST_OK, 32'h0, 1, 16'd1}},
      '{0, 0, rpa_pkg::OP_FREE, 32'h4000, 1, '{rpa_pkg::ST_OK, 32'h0, 0, 16'd2}},
      // free and incref of a free page
      '{0, 0, rpa_pkg::OP_FREE, 32'h4000, 1, '{rpa_pkg::ST_NOT_ALLOC, 32'h0, 0, 16'd2}},
      '{0, 0, rpa_pkg::OP_INCR, 32'h4000, 1, '{rpa_pkg::ST_NOT_ALLOC, 32'h0, 0, 16'd2}},
      // misaligned, below base, past the region
      '{0, 0, rpa_pkg::OP_FREE, 32'h2001, 1, '{rpa_pkg::ST_BAD_ADDR, 32'h0, 0, 16'd2}},
      '{0, 0, rpa_pkg::OP_FREE, 32'h1000, 1, '{rpa_pkg::ST_BAD_ADDR, 32'h0, 0, 16'd2}},
      '{0, 0, rpa_pkg::OP_INCR, 32'h5000, 1, '{rpa_pkg::ST_BAD_ADDR, 32'h0, 0, 16'd2}},
      '{0, 0, rpa_pkg::OP_ALLOC, 32'h0, 0, '0},
      '{0, 0, rpa_pkg::OP_ALLOC, 32'h0, 0, '0},
      '{0, 0, rpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1, '{rpa_pkg::ST_EMPTY, 32'h0, 0, 16'd0}},
      // repeated init clears every count
      '{0, 0, rpa_pkg::OP_INIT, 32'h0, 1, '{rpa_pkg::ST_OK, 32'h0, 0, 16'd3}},
      '{0, 0, rpa_pkg::OP_FREE, 32'h3000, 1, '{rpa_pkg::ST_NOT_ALLOC, 32'h0, 0, 16'd3}},
      // a base rounded past the 32-bit space holds nothing
      '{1, rpa_pkg::CFG_REGION_START, rpa_pkg::OP_INIT, 32'hFFFF_FFFF, 0, '0},
      '{0, 0, rpa_pkg::OP_INCR, 32'h3000, 0, '0},
      '{0, 0, rpa_pkg::OP_INIT, 32'h0, 1, '{rpa_pkg::ST_OK, 32'h0, 0, 16'd0}},
      '{0, 0, rpa_pkg::OP_ALLOC, 32'h0, 1, '{rpa_pkg::ST_EMPTY, 32'h0, 0, 16'd0}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        wait_drained();
        write_reg(dir_table[i].reg_sel, dir_table[i].val);
      end else begin
        send_item(dir_table[i].op, dir_table[i].val, dir_table[i].typed, dir_table[i].res);
      end
    end
    wait_drained();

    // random phases, each on a fresh register setting
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin  // whole 32-bit space, clamped to the full page table
          write_reg(rpa_pkg::CFG_REGION_START, 32'h0);
          write_reg(rpa_pkg::CFG_REGION_END, 32'hFFFF_FFFF);
        end
        1: begin  // zero-sized region
          write_reg(rpa_pkg::CFG_REGION_START, 32'h0);
          write_reg(rpa_pkg::CFG_REGION_END, 32'h0);
        end
        2: begin  // start above end
          write_reg(rpa_pkg::CFG_REGION_START, $urandom_range(32'h1000_0000, 32'hFFFF_FFFF));
          write_reg(rpa_pkg::CFG_REGION_END, $urandom_range(0, 32'h0FFF_FFFF));
        end
        11: begin // reset-value region: exactly the full table
          write_reg(rpa_pkg::CFG_REGION_START, 32'h8000_0000);
          write_reg(rpa_pkg::CFG_REGION_END, 32'h8800_0000);
        end
        default: pick_small_region();
      endcase
      tx_no_idle = (ph % 4 == 3);
      rx_no_idle = (ph % 5 == 4);
      send_item(rpa_pkg::OP_INIT, $urandom(), 0, '0);
      if (ph == 5) begin
        // sender floods while the receiver stalls for a long stretch
        tx_no_idle  = 1;
        rx_hold_req = 1;
      end
      for (int k = 0; k < 100; k++) random_item();
      tx_no_idle = 0;
      // sender pauses here until every result is back
      wait_drained();
    end

    // one page through several references and back to free, no idling on either side
    tx_no_idle = 1;
    rx_no_idle = 1;
    pick_small_region();
    send_item(rpa_pkg::OP_INIT, 32'h0, 0, '0);
    send_item(rpa_pkg::OP_ALLOC, 32'h0, 0, '0);
    for (int k = 0; k < 8; k++) send_item(rpa_pkg::OP_INCR, recent_pages[0], 0, '0);
    for (int k = 0; k < 10; k++) send_item(rpa_pkg::OP_FREE, recent_pages[0], 0, '0);
    send_item(rpa_pkg::OP_INCR, recent_pages[0], 0, '0);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("%0d items sent, %0d results checked", items_sent, beats_seen);
    $display("status mix ok/empty/bad/unalloc/sat: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/rpa_pkg.sv
sv/rpa_front.sv
sv/rpa_back.sv
sv/refcounted_page_allocator.sv
sv/rpa_checker.sv
tb/testbench.sv
